// ===== rtl/hml_pkg.sv =====
// Shared types and constants for the histogram matching table block.
package hml_pkg;

	localparam int BINS = 256;

	localparam logic [1:0] MODE_REF = 2'd0;
	localparam logic [1:0] MODE_SRC = 2'd1;
	localparam logic [1:0] MODE_MAP = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] sample_0;
		logic [7:0] sample_1;
		logic [7:0] sample_2;
		logic       frame_end;
	} pix_t;

	typedef struct packed {
		logic [7:0] mapped_0;
		logic [7:0] mapped_1;
		logic [7:0] mapped_2;
	} res_t;

	typedef struct packed {
		logic start_clr;
		logic start_bld;
		logic active;
	} lane_ctl_t;

endpackage

// ===== rtl/histogram_matching_lut.sv =====
// Top level: pixel channel, config register, control sequencer and channel lanes.
// Histogram and remap pixels are taken one per cycle unless pix_stall holds the channel; a remap result
// is registered in the lane and then in an output register, where it is held while stalled.
// The frame-end source pixel stalls input for the table build: cumulation, a bin merge of at most
// 511 steps (each a read, a multiply and a compare) and a histogram clear.
// After reset a clearing pass over all memories runs before the first pixel is taken.
module histogram_matching_lut #(
	parameter int MAX_PIXELS   = 4194304,
	parameter int MAX_CHANNELS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  hml_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_stall,
	output hml_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_data
);
	localparam int NL = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FE   = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0]  st_q;
	logic [1:0]  chan_q;
	logic [1:0]  n_eff;
	logic [2:0]  active;
	logic [2:0]  idle;
	logic [7:0]  map_q [3];
	logic [7:0]  samp [3];
	logic        m_vld_s1;
	logic        out_vld_q;
	hml_pkg::res_t out_q;
	logic        acc, out_free, s1_blk, hist;
	hml_pkg::lane_ctl_t ctl [3];

	assign cfg_ready = 1'b1;
	assign n_eff     = (chan_q == 2'd0) ? 2'd1 : chan_q;
	assign samp[0]   = pix.sample_0;
	assign samp[1]   = pix.sample_1;
	assign samp[2]   = pix.sample_2;

	assign out_free  = !out_vld_q || !res_stall;
	assign s1_blk    = m_vld_s1 && !out_free;
	assign pix_stall = (st_q != ST_RUN) || s1_blk;
	assign acc       = pix_valid && !pix_stall;
	assign hist      = acc && (pix.mode == hml_pkg::MODE_REF || pix.mode == hml_pkg::MODE_SRC);
	assign res_valid = out_vld_q;
	assign res       = out_q;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		assign active[c] = (2'(c) < n_eff);
		assign ctl[c] = '{start_clr: (st_q == ST_INIT), start_bld: (st_q == ST_FE),
			active: active[c]};
		if (c < NL) begin : g_on
			hml_lane #(
				.MAX_PIXELS(MAX_PIXELS)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl[c]),
				.hist_we (hist && active[c]),
				.hist_src(pix.mode == hml_pkg::MODE_SRC),
				.map_re  (acc && pix.mode == hml_pkg::MODE_MAP),
				.samp    (samp[c]),
				.map_q   (map_q[c]),
				.idle    (idle[c])
			);
		end else begin : g_off
			assign map_q[c] = 8'd0;
			assign idle[c]  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_vld_s1 && out_free) begin
			out_q.mapped_0 <= active[0] ? map_q[0] : 8'd0;
			out_q.mapped_1 <= active[1] ? map_q[1] : 8'd0;
			out_q.mapped_2 <= active[2] ? map_q[2] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_INIT;
			chan_q    <= 2'd3;
			m_vld_s1  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chan_q <= cfg_data;
			end
			m_vld_s1 <= (acc && pix.mode == hml_pkg::MODE_MAP) || s1_blk;
			if (m_vld_s1 && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!res_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_INIT: st_q <= ST_WAIT;
				ST_RUN: begin
					if (acc && pix.mode == hml_pkg::MODE_SRC && pix.frame_end) begin
						st_q <= ST_FE;
					end
				end
				ST_FE: st_q <= ST_WAIT;
				default: begin
					if (&idle) begin
						st_q <= ST_RUN;
					end
				end
			endcase
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_RUN) |-> pix_stall)
		else $error("pixel taken outside run state");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_blk |=> m_vld_s1)
		else $error("blocked remap result lost");

	a_fe_build: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.mode == hml_pkg::MODE_SRC && pix.frame_end) |=> (st_q == ST_FE))
		else $error("frame end did not start table build");

endmodule

// ===== rtl/hml_lane.sv =====
// One channel: histogram memories, table build sequencer and mapping table.
module hml_lane #(
	parameter int MAX_PIXELS = 4194304
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hml_pkg::lane_ctl_t ctl,
	input  logic              hist_we,
	input  logic              hist_src,
	input  logic              map_re,
	input  logic [7:0]        samp,
	output logic [7:0]        map_q,
	output logic              idle
);
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_PIXELS);
	localparam int NB = hml_pkg::BINS;

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_CLR  = 3'd1;
	localparam logic [2:0] L_ACC  = 3'd2;
	localparam logic [2:0] L_SRCH = 3'd3;
	localparam logic [2:0] L_HCLR = 3'd4;

	localparam logic [1:0] SP_RD  = 2'd0;
	localparam logic [1:0] SP_MUL = 2'd1;
	localparam logic [1:0] SP_CMP = 2'd2;

	logic [CW-1:0] ref_mem [NB];
	logic [CW-1:0] src_mem [NB];
	logic [7:0]    map_mem [NB];

	logic [2:0]      st_q;
	logic [1:0]      sp_q;
	logic [8:0]      cnt_q;
	logic [7:0]      j_q, k_q;
	logic            zero_q;
	logic [CW-1:0]   racc_q, sacc_q;
	logic [2*CW-1:0] lhs_q, tgt_q;
	logic [CW-1:0]   ref_rd_q, src_rd_q;
	logic            h_vld_s1, h_src_s1;
	logic [7:0]      h_addr_s1;
	logic            a_vld_s1;
	logic [7:0]      a_idx_s1;
	logic            wf_vld_q, wf_src_q;
	logic [7:0]      wf_addr_q;
	logic [CW-1:0]   wf_val_q;

	logic [CW-1:0] h_base, h_new, r_new, s_new;
	logic [CW:0]   r_sum, s_sum;
	logic          k_adv;
	logic          ref_we, src_we, map_we;
	logic [7:0]    ref_wa, src_wa, map_wa, ref_ra, src_ra;
	logic [CW-1:0] ref_wd, src_wd;
	logic [7:0]    map_wd;

	assign idle = (st_q == L_IDLE);

	always_comb begin
		if (wf_vld_q && wf_src_q == h_src_s1 && wf_addr_q == h_addr_s1) begin
			h_base = wf_val_q;
		end else begin
			h_base = h_src_s1 ? src_rd_q : ref_rd_q;
		end
		h_new = (h_base < CMAX) ? h_base + 1'b1 : CMAX;
		r_sum = {1'b0, racc_q} + {1'b0, ref_rd_q};
		s_sum = {1'b0, sacc_q} + {1'b0, src_rd_q};
		r_new = (r_sum > {1'b0, CMAX}) ? CMAX : r_sum[CW-1:0];
		s_new = (s_sum > {1'b0, CMAX}) ? CMAX : s_sum[CW-1:0];
		k_adv = (k_q != 8'hFF) && (lhs_q < tgt_q);
	end

	always_comb begin
		ref_we = 1'b0;
		src_we = 1'b0;
		ref_wa = cnt_q[7:0];
		src_wa = cnt_q[7:0];
		ref_wd = '0;
		src_wd = '0;
		map_we = 1'b0;
		map_wa = cnt_q[7:0];
		map_wd = 8'd0;
		ref_ra = samp;
		src_ra = samp;
		unique case (st_q)
			L_CLR: begin
				ref_we = 1'b1;
				src_we = 1'b1;
				map_we = 1'b1;
			end
			L_HCLR: begin
				ref_we = 1'b1;
				src_we = 1'b1;
			end
			L_ACC: begin
				ref_ra = cnt_q[7:0];
				src_ra = cnt_q[7:0];
				ref_we = a_vld_s1;
				src_we = a_vld_s1;
				ref_wa = a_idx_s1;
				src_wa = a_idx_s1;
				ref_wd = r_new;
				src_wd = s_new;
			end
			L_SRCH: begin
				ref_ra = k_q;
				src_ra = j_q;
				map_we = (sp_q == SP_CMP) && !k_adv;
				map_wa = j_q;
				map_wd = zero_q ? 8'd0 : k_q;
			end
			default: begin
				ref_we = h_vld_s1 && !h_src_s1;
				src_we = h_vld_s1 && h_src_s1;
				ref_wa = h_addr_s1;
				src_wa = h_addr_s1;
				ref_wd = h_new;
				src_wd = h_new;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_wa] <= ref_wd;
		end
		if (src_we) begin
			src_mem[src_wa] <= src_wd;
		end
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		ref_rd_q <= ref_mem[ref_ra];
		src_rd_q <= src_mem[src_ra];
		if (map_re) begin
			map_q <= map_mem[samp];
		end
	end

	always_ff @(posedge clk) begin
		h_src_s1  <= hist_src;
		h_addr_s1 <= samp;
		a_idx_s1  <= cnt_q[7:0];
		wf_src_q  <= h_src_s1;
		wf_addr_q <= h_addr_s1;
		wf_val_q  <= h_new;
		if (st_q == L_SRCH && sp_q == SP_MUL) begin
			lhs_q <= ref_rd_q * sacc_q;
			tgt_q <= src_rd_q * racc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= L_IDLE;
			sp_q     <= SP_RD;
			cnt_q    <= '0;
			j_q      <= '0;
			k_q      <= '0;
			zero_q   <= 1'b0;
			racc_q   <= '0;
			sacc_q   <= '0;
			h_vld_s1 <= 1'b0;
			a_vld_s1 <= 1'b0;
			wf_vld_q <= 1'b0;
		end else begin
			h_vld_s1 <= hist_we && (st_q == L_IDLE);
			wf_vld_q <= h_vld_s1;
			a_vld_s1 <= (st_q == L_ACC) && !cnt_q[8];
			unique case (st_q)
				L_IDLE: begin
					cnt_q  <= '0;
					racc_q <= '0;
					sacc_q <= '0;
					if (ctl.start_clr) begin
						st_q <= L_CLR;
					end else if (ctl.start_bld) begin
						st_q <= L_ACC;
					end
				end
				L_CLR, L_HCLR: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q[7:0] == 8'hFF) begin
						st_q <= L_IDLE;
					end
				end
				L_ACC: begin
					if (!cnt_q[8]) begin
						cnt_q <= cnt_q + 9'd1;
					end
					if (a_vld_s1) begin
						racc_q <= r_new;
						sacc_q <= s_new;
					end
					if (cnt_q[8] && !a_vld_s1) begin
						st_q   <= L_SRCH;
						sp_q   <= SP_RD;
						j_q    <= '0;
						k_q    <= '0;
						zero_q <= !ctl.active || racc_q == '0 || sacc_q == '0;
					end
				end
				L_SRCH: begin
					unique case (sp_q)
						SP_RD:  sp_q <= SP_MUL;
						SP_MUL: sp_q <= SP_CMP;
						default: begin
							sp_q <= SP_RD;
							if (k_adv) begin
								k_q <= k_q + 8'd1;
							end else if (j_q == 8'hFF) begin
								st_q  <= L_HCLR;
								cnt_q <= '0;
							end else begin
								j_q <= j_q + 8'd1;
							end
						end
					endcase
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

endmodule
